// ----- sv/indexed_list_table_assert.svh -----
// ----------------------------------------------------------------------------
// indexed_list_table_assert.svh
// Assertion macros used by the list table checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_TABLE_ASSERT_SVH
`define INDEXED_LIST_TABLE_ASSERT_SVH

// same-cycle implication
`define ILT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list table assertion failed");

// next-cycle implication
`define ILT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list table assertion failed");

`endif

// ----- sv/ilt_pkg.sv -----
// ----------------------------------------------------------------------------
// ilt_pkg
// Types, codes and constants of the indexed list table.
// ----------------------------------------------------------------------------
package ilt_pkg;

  localparam int CAPACITY = 256;
  localparam int POS_W    = 16;
  localparam int VAL_W    = 32;
  localparam int ENTRY_W  = 9;

  localparam logic [2:0] CMD_GET    = 3'd0;
  localparam logic [2:0] CMD_HEAD   = 3'd1;
  localparam logic [2:0] CMD_TAIL   = 3'd2;
  localparam logic [2:0] CMD_INDEX  = 3'd3;
  localparam logic [2:0] CMD_DELETE = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
    logic [ENTRY_W-1:0]      entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_DRAIN,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_shift;
    logic shift_more;
  } ctrl_stat_t;

endpackage

// ----- sv/indexed_list_table.sv -----
// Steps: get, rejected and unknown commands go from accept through check to the result word;
// insert and delete also shift n entries (n up to CAPACITY - 1), drain and commit.
// One word at a time: a new word is taken only once the last result word is loaded;
// the entry memory moves one entry per cycle while shifting.
// Reset: synchronous; clears the count and handshake state, memory is not cleared.
// ----------------------------------------------------------------------------
// indexed_list_table
// Ordered list of signed words with get, insert and delete by position.
// ----------------------------------------------------------------------------
module indexed_list_table #(
  parameter int CAPACITY = ilt_pkg::CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ilt_pkg::req_t req_word,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ilt_pkg::rsp_t rsp_word
);

  ilt_pkg::ctrl_cmd_t  cmd;
  ilt_pkg::ctrl_stat_t stat;

  ilt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ilt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_word (req_word),
    .cmd      (cmd),
    .stat     (stat),
    .rsp_word (rsp_word)
  );

endmodule

// ----- sv/ilt_datapath.sv -----
// ----------------------------------------------------------------------------
// ilt_datapath
// Entry memory, count, shift cursor and result register.
// ----------------------------------------------------------------------------
module ilt_datapath #(
  parameter int CAPACITY = ilt_pkg::CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  ilt_pkg::req_t      req_word,
  input  ilt_pkg::ctrl_cmd_t cmd,
  output ilt_pkg::ctrl_stat_t stat,
  output ilt_pkg::rsp_t      rsp_word
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [2:0]                      command;
  logic [ilt_pkg::POS_W-1:0]       position;
  logic signed [ilt_pkg::VAL_W-1:0] value;
  logic [CW-1:0]                   count;
  logic [CW-1:0]                   cursor;
  logic                            wb_valid;
  logic [AW-1:0]                   wb_addr;
  logic [1:0]                      st;
  logic [ilt_pkg::VAL_W-1:0]       rdata;
  logic [ilt_pkg::VAL_W-1:0]       mem [0:CAPACITY-1];
  ilt_pkg::rsp_t                   rsp;

  logic                      is_get, is_ins, is_del;
  logic [ilt_pkg::POS_W-1:0] count_ext;
  logic                      full;
  logic [1:0]                st_calc;
  logic [CW-1:0]             tgt;
  logic [CW-1:0]             cur_dn, cur_up;
  logic [CW:0]               cur_up_ext;
  logic                      rd_en;
  logic [AW-1:0]             raddr;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [ilt_pkg::VAL_W-1:0] wdata;

  assign is_get    = (command == ilt_pkg::CMD_GET);
  assign is_ins    = (command == ilt_pkg::CMD_HEAD) || (command == ilt_pkg::CMD_TAIL) ||
                     (command == ilt_pkg::CMD_INDEX);
  assign is_del    = (command == ilt_pkg::CMD_DELETE);
  assign count_ext = ilt_pkg::POS_W'(count);
  assign full      = (count == CW'(CAPACITY));
  assign cur_dn    = cursor - CW'(1);
  assign cur_up    = cursor + CW'(1);
  assign cur_up_ext = {1'b0, cursor} + (CW+1)'(1);

  always_comb begin
    case (command)
      ilt_pkg::CMD_GET:    st_calc = (position < count_ext) ? ilt_pkg::ST_OK : ilt_pkg::ST_RANGE;
      ilt_pkg::CMD_HEAD,
      ilt_pkg::CMD_TAIL:   st_calc = full ? ilt_pkg::ST_FULL : ilt_pkg::ST_OK;
      ilt_pkg::CMD_INDEX:  st_calc = (position > count_ext) ? ilt_pkg::ST_RANGE :
                                     full ? ilt_pkg::ST_FULL : ilt_pkg::ST_OK;
      ilt_pkg::CMD_DELETE: st_calc = (position < count_ext) ? ilt_pkg::ST_OK : ilt_pkg::ST_RANGE;
      default:             st_calc = ilt_pkg::ST_OK;
    endcase
  end

  always_comb begin
    case (command)
      ilt_pkg::CMD_HEAD: tgt = '0;
      ilt_pkg::CMD_TAIL: tgt = count;
      default:           tgt = position[CW-1:0];
    endcase
  end

  assign stat.go_shift   = (is_ins || is_del) && (st_calc == ilt_pkg::ST_OK);
  assign stat.shift_more = is_ins ? (cursor > tgt) : (cur_up_ext < {1'b0, count});

  // read port: get lookup or shift source
  always_comb begin
    rd_en = 1'b0;
    raddr = position[AW-1:0];
    if (cmd.check && is_get && (st_calc == ilt_pkg::ST_OK)) begin
      rd_en = 1'b1;
    end else if (cmd.step) begin
      rd_en = 1'b1;
      raddr = is_ins ? cur_dn[AW-1:0] : cur_up[AW-1:0];
    end
  end

  // write port: shift write-back, then the inserted word
  always_comb begin
    we    = 1'b0;
    waddr = wb_addr;
    wdata = rdata;
    if (wb_valid) begin
      we = 1'b1;
    end else if (cmd.commit && is_ins && (st == ilt_pkg::ST_OK)) begin
      we    = 1'b1;
      waddr = tgt[AW-1:0];
      wdata = value;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= cmd.step;
      if (cmd.commit && (st == ilt_pkg::ST_OK)) begin
        if (is_ins) begin
          count <= count + CW'(1);
        end else if (is_del) begin
          count <= count - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command  <= req_word.command;
      position <= req_word.position;
      value    <= req_word.value;
    end
    if (cmd.check) begin
      st     <= st_calc;
      cursor <= is_ins ? count : position[CW-1:0];
    end else if (cmd.step) begin
      cursor <= is_ins ? cur_dn : cur_up;
    end
    if (cmd.step) begin
      wb_addr <= cursor[AW-1:0];
    end
    if (cmd.load_out) begin
      if (is_get) begin
        rsp.read_value <= (st == ilt_pkg::ST_OK) ? rdata : '1;
      end else begin
        rsp.read_value <= '0;
      end
      rsp.status      <= st;
      rsp.entry_count <= ilt_pkg::ENTRY_W'(count);
    end
  end

  assign rsp_word = rsp;

endmodule

// ----- sv/ilt_ctrl.sv -----
// ----------------------------------------------------------------------------
// ilt_ctrl
// Command sequencer: check, shift, commit and result handshake.
// ----------------------------------------------------------------------------
module ilt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  ilt_pkg::ctrl_stat_t stat,
  output ilt_pkg::ctrl_cmd_t  cmd
);

  ilt_pkg::state_t state, state_next;
  logic            rsp_valid_next;
  logic            out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    case (state)
      ilt_pkg::S_IDLE:   if (req_valid) state_next = ilt_pkg::S_CHECK;
      ilt_pkg::S_CHECK:  state_next = stat.go_shift ? ilt_pkg::S_SHIFT : ilt_pkg::S_DONE;
      ilt_pkg::S_SHIFT:  if (!stat.shift_more) state_next = ilt_pkg::S_DRAIN;
      ilt_pkg::S_DRAIN:  state_next = ilt_pkg::S_COMMIT;
      ilt_pkg::S_COMMIT: state_next = ilt_pkg::S_DONE;
      ilt_pkg::S_DONE:   if (out_free) state_next = ilt_pkg::S_IDLE;
      default:           state_next = ilt_pkg::S_IDLE;
    endcase
    if (cmd.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_comb begin
    req_ready    = (state == ilt_pkg::S_IDLE);
    cmd.load     = (state == ilt_pkg::S_IDLE) && req_valid;
    cmd.check    = (state == ilt_pkg::S_CHECK);
    cmd.step     = (state == ilt_pkg::S_SHIFT) && stat.shift_more;
    cmd.commit   = (state == ilt_pkg::S_COMMIT);
    cmd.load_out = (state == ilt_pkg::S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ilt_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ----- sv/ilt_checker.sv -----
// ----------------------------------------------------------------------------
// ilt_checker
// Port-level checks of the list table, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_list_table_assert.svh"

module ilt_checker #(
  parameter int CAPACITY = ilt_pkg::CAPACITY
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ilt_pkg::rsp_t rsp_word
);

  localparam logic [ilt_pkg::ENTRY_W-1:0] CAP_MASKED = ilt_pkg::ENTRY_W'(CAPACITY);
  localparam bit CAP_FITS = (CAPACITY < (1 << ilt_pkg::ENTRY_W));

  `ILT_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
  `ILT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
  `ILT_ASSERT_NOW(a_count_bound, rsp_valid, !CAP_FITS || (rsp_word.entry_count <= CAP_MASKED))
  `ILT_ASSERT_NOW(a_full_count, rsp_valid && (rsp_word.status == ilt_pkg::ST_FULL), (rsp_word.entry_count == CAP_MASKED) && (rsp_word.read_value == '0))

endmodule

bind indexed_list_table ilt_checker #(.CAPACITY(CAPACITY)) u_ilt_checker (.*);

// ----- tb/sv/tb_indexed_list_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_table
// Drives get, insert, delete and unknown words into the list table and
// checks each result word against a typed row or a running list copy.
// A short directed table comes first, then random phases that grow, fill,
// overflow and drain the list; all but fill idle and back-pressure at random.
// ----------------------------------------------------------------------------
module tb_indexed_list_table;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 300;

  typedef enum {PH_MIX, PH_FILL, PH_FULL, PH_DRAIN} phase_t;

  typedef struct {
    ilt_pkg::req_t word;
    bit            typed;
    ilt_pkg::rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  ilt_pkg::req_t req_word = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  ilt_pkg::rsp_t rsp_word;

  logic signed [ilt_pkg::VAL_W-1:0] list_mem [ilt_pkg::CAPACITY];
  int unsigned list_len = 0;
  ilt_pkg::rsp_t expected_rsp [$];
  dir_row_t directed_rows [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_cycles = 0;
  bit steady = 1'b0;

  indexed_list_table uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_word (req_word),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_word (rsp_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void list_insert(int unsigned p, logic signed [ilt_pkg::VAL_W-1:0] v);
    for (int unsigned i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
    list_mem[p] = v;
    list_len++;
  endfunction

  function automatic ilt_pkg::rsp_t list_apply(ilt_pkg::req_t w);
    ilt_pkg::rsp_t r;
    int unsigned p;
    r = '0;
    r.status = ilt_pkg::ST_OK;
    p = w.position;
    case (w.command)
      ilt_pkg::CMD_GET: begin
        if (p < list_len) begin
          r.read_value = list_mem[p];
        end else begin
          r.read_value = -1;
          r.status = ilt_pkg::ST_RANGE;
        end
      end
      ilt_pkg::CMD_HEAD: begin
        if (list_len >= ilt_pkg::CAPACITY) r.status = ilt_pkg::ST_FULL;
        else list_insert(0, w.value);
      end
      ilt_pkg::CMD_TAIL: begin
        if (list_len >= ilt_pkg::CAPACITY) r.status = ilt_pkg::ST_FULL;
        else list_insert(list_len, w.value);
      end
      ilt_pkg::CMD_INDEX: begin
        if (p > list_len) r.status = ilt_pkg::ST_RANGE;
        else if (list_len >= ilt_pkg::CAPACITY) r.status = ilt_pkg::ST_FULL;
        else list_insert(p, w.value);
      end
      ilt_pkg::CMD_DELETE: begin
        if (p >= list_len) begin
          r.status = ilt_pkg::ST_RANGE;
        end else begin
          for (int unsigned i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.entry_count = ilt_pkg::ENTRY_W'(list_len);
    return r;
  endfunction

  function automatic ilt_pkg::req_t pick_word(phase_t ph);
    ilt_pkg::req_t w;
    int w_get, w_head, w_tail, w_idx, w_del, w_unk, total, r;
    int unsigned hi;
    case (ph)
      PH_MIX: begin
        w_get = 25; w_head = 12; w_tail = 12; w_idx = 16; w_unk = 5;
        w_del = (list_len > 24) ? 35 : 15;
      end
      PH_FILL: begin
        w_get = 10; w_head = 25; w_tail = 25; w_idx = 35; w_del = 0; w_unk = 5;
      end
      PH_FULL: begin
        w_get = 20; w_head = 20; w_tail = 20; w_idx = 25; w_del = 10; w_unk = 5;
      end
      default: begin
        w_get = 25; w_head = 8; w_tail = 8; w_idx = 10; w_del = 55; w_unk = 5;
      end
    endcase
    total = w_get + w_head + w_tail + w_idx + w_del + w_unk;
    r = $urandom_range(total - 1);
    if (r < w_get) w.command = ilt_pkg::CMD_GET;
    else if (r < w_get + w_head) w.command = ilt_pkg::CMD_HEAD;
    else if (r < w_get + w_head + w_tail) w.command = ilt_pkg::CMD_TAIL;
    else if (r < w_get + w_head + w_tail + w_idx) w.command = ilt_pkg::CMD_INDEX;
    else if (r < total - w_unk) w.command = ilt_pkg::CMD_DELETE;
    else w.command = 3'(ilt_pkg::CMD_DELETE + 1 + $urandom_range(2));

    if (w.command == ilt_pkg::CMD_INDEX) hi = list_len;
    else hi = (list_len == 0) ? 0 : list_len - 1;
    r = $urandom_range(99);
    if (w.command == ilt_pkg::CMD_HEAD || w.command == ilt_pkg::CMD_TAIL ||
        w.command > ilt_pkg::CMD_DELETE)
      w.position = ilt_pkg::POS_W'($urandom);
    else if (r < 80) w.position = ilt_pkg::POS_W'($urandom_range(hi));
    else if (r < 90) w.position = ilt_pkg::POS_W'(list_len + $urandom_range(1));
    else w.position = ilt_pkg::POS_W'($urandom);

    r = $urandom_range(99);
    case (r)
      0: w.value = 32'sh8000_0000;
      1: w.value = 32'sh7FFF_FFFF;
      2: w.value = '0;
      3: w.value = -1;
      default: w.value = $urandom;
    endcase
    return w;
  endfunction

  task automatic add_row(logic [2:0] cmd, logic [ilt_pkg::POS_W-1:0] pos,
                         logic [ilt_pkg::VAL_W-1:0] val,
                         bit typed = 1'b0, logic [ilt_pkg::VAL_W-1:0] rd = '0,
                         logic [1:0] st = ilt_pkg::ST_OK,
                         logic [ilt_pkg::ENTRY_W-1:0] cnt = '0);
    dir_row_t row;
    row.word.command = cmd;
    row.word.position = pos;
    row.word.value = val;
    row.typed = typed;
    row.rsp.read_value = rd;
    row.rsp.status = st;
    row.rsp.entry_count = cnt;
    directed_rows.push_back(row);
  endtask

  task automatic send_word(ilt_pkg::req_t w, bit typed, ilt_pkg::rsp_t typed_rsp);
    int gap;
    ilt_pkg::rsp_t predicted;
    gap = 0;
    while (!steady && $urandom_range(99) < 21) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word <= w;
    do @(posedge clk); while (!req_ready);
    predicted = list_apply(w);
    expected_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_rsp.size() != 0);
  endtask

  always @(posedge clk) begin
    ilt_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, rsp_word);
        mismatch_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_word.read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d, actual %0d", $time,
                   want.read_value, rsp_word.read_value);
          mismatch_count++;
        end
        if (rsp_word.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time,
                   want.status, rsp_word.status);
          mismatch_count++;
        end
        if (rsp_word.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d, actual %0d", $time,
                   want.entry_count, rsp_word.entry_count);
          mismatch_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      rsp_ready <= 1'b0;
    end else if (steady) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= 21);
    end
  end

  initial begin
    // after reset, empty list
    add_row(ilt_pkg::CMD_GET, 16'd0, 32'd0, 1'b1, -1, ilt_pkg::ST_RANGE, 9'd0);
    add_row(ilt_pkg::CMD_DELETE, 16'd0, 32'd0, 1'b1, 32'd0, ilt_pkg::ST_RANGE, 9'd0);
    add_row(ilt_pkg::CMD_DELETE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, ilt_pkg::ST_RANGE,
            9'd0);
    add_row(ilt_pkg::CMD_INDEX, 16'd1, 32'd5, 1'b1, 32'd0, ilt_pkg::ST_RANGE, 9'd0);
    add_row(ilt_pkg::CMD_HEAD, 16'hFFFF, 32'h8000_0000, 1'b1, 32'd0, ilt_pkg::ST_OK, 9'd1);
    add_row(ilt_pkg::CMD_TAIL, 16'd0, 32'h7FFF_FFFF, 1'b1, 32'd0, ilt_pkg::ST_OK, 9'd2);
    add_row(ilt_pkg::CMD_INDEX, 16'd2, 32'hFFFF_FFFF);
    add_row(ilt_pkg::CMD_INDEX, 16'd0, 32'h5555_5555);
    add_row(ilt_pkg::CMD_INDEX, 16'd2, 32'hAAAA_AAAA);
    add_row(ilt_pkg::CMD_GET, 16'd0, 32'd0);
    add_row(ilt_pkg::CMD_GET, 16'd4, 32'hFFFF_FFFF);
    add_row(ilt_pkg::CMD_GET, 16'd2, 32'd0);
    add_row(ilt_pkg::CMD_GET, 16'd5, 32'd0, 1'b1, -1, ilt_pkg::ST_RANGE, 9'd5);
    add_row(ilt_pkg::CMD_GET, 16'hFFFF, 32'd0, 1'b1, -1, ilt_pkg::ST_RANGE, 9'd5);
    add_row(ilt_pkg::CMD_INDEX, 16'd6, 32'd1, 1'b1, 32'd0, ilt_pkg::ST_RANGE, 9'd5);
    add_row(ilt_pkg::CMD_INDEX, 16'hFFFF, 32'd1, 1'b1, 32'd0, ilt_pkg::ST_RANGE, 9'd5);
    add_row(3'd5, 16'd0, 32'h1234_5678, 1'b1, 32'd0, ilt_pkg::ST_OK, 9'd5);
    add_row(3'd6, 16'd1, 32'd0, 1'b1, 32'd0, ilt_pkg::ST_OK, 9'd5);
    add_row(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, ilt_pkg::ST_OK, 9'd5);
    add_row(ilt_pkg::CMD_DELETE, 16'd0, 32'd0);
    add_row(ilt_pkg::CMD_DELETE, 16'd3, 32'd0);
    add_row(ilt_pkg::CMD_DELETE, 16'd3, 32'd0, 1'b1, 32'd0, ilt_pkg::ST_RANGE, 9'd3);
    add_row(ilt_pkg::CMD_GET, 16'd1, 32'd0);
    add_row(ilt_pkg::CMD_HEAD, 16'd0, 32'd0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].rsp);
    wait_drained();

    for (int i = 0; i < 300; i++) begin
      if (i == 100) hold_cycles = 600;
      send_word(pick_word(PH_MIX), 1'b0, '0);
    end

    // fill to capacity with no idling on either side
    steady = 1'b1;
    while (list_len < ilt_pkg::CAPACITY) send_word(pick_word(PH_FILL), 1'b0, '0);
    steady = 1'b0;
    for (int i = 0; i < 40; i++) send_word(pick_word(PH_FULL), 1'b0, '0);
    wait_drained();

    for (int i = 0; i < 300; i++) send_word(pick_word(PH_DRAIN), 1'b0, '0);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- indexed_list_table.f -----
+incdir+sv
sv/ilt_pkg.sv
sv/ilt_datapath.sv
sv/ilt_ctrl.sv
sv/indexed_list_table.sv
sv/ilt_checker.sv
tb/sv/tb_indexed_list_table.sv
